>>> rtl/nor_flash_command_sequencer_defines.svh
// Assertion macros used by the sequencer's back end (nfcs_back).
`ifndef NOR_FLASH_COMMAND_SEQUENCER_DEFINES_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

`define NFCS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("nfcs assertion failed");

`define NFCS_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("nfcs forbidden condition seen");

`else

`define NFCS_ASSERT(label, prop)

`define NFCS_ASSERT_NEVER(label, expr)

`endif

`endif

>>> rtl/nfcs_pkg.sv
// Types, constants and the command step table of the NOR flash command sequencer.
package nfcs_pkg;

    localparam int WORD_ADDR_BITS = 21;
    localparam int DATA_BITS      = 16;
    localparam int STEP_BITS      = 3;
    localparam int DQ6_BIT        = 6;

    localparam int CQ_DEPTH    = 4;
    localparam int CQ_IDX_BITS = 2;
    localparam int CQ_CNT_BITS = 3;

    localparam logic [WORD_ADDR_BITS-1:0] UNLOCK_A = 21'h000555;
    localparam logic [WORD_ADDR_BITS-1:0] UNLOCK_B = 21'h0002AA;

    localparam logic [DATA_BITS-1:0] DATA_UNLOCK_A = 16'h00AA;
    localparam logic [DATA_BITS-1:0] DATA_UNLOCK_B = 16'h0055;
    localparam logic [DATA_BITS-1:0] DATA_ERASE    = 16'h0080;
    localparam logic [DATA_BITS-1:0] DATA_SECTOR   = 16'h0030;
    localparam logic [DATA_BITS-1:0] DATA_PROGRAM  = 16'h00A0;
    localparam logic [DATA_BITS-1:0] DATA_RESET    = 16'h00F0;

    localparam logic [STEP_BITS-1:0] MAX_STEP = 3'd6;

    typedef enum logic [1:0] {
        OP_PROGRAM = 2'd0,
        OP_ERASE   = 2'd1,
        OP_RESET   = 2'd2,
        OP_STATUS  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_POLL  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CMD_PROGRAM = 3'd0,
        CMD_ERASE   = 3'd1,
        CMD_RESET   = 3'd2,
        CMD_POLL    = 3'd3,
        CMD_DONE    = 3'd4,
        CMD_ERROR   = 3'd5
    } cmd_t;

    // One classified request as it waits between the front and back ends.
    typedef struct packed {
        cmd_t                      cmd;
        logic [WORD_ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0]      data;
    } desc_t;

    typedef struct packed {
        kind_t                     kind;
        logic [WORD_ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0]      data;
        logic                      last;
    } result_t;

    // Bus access emitted at a given step of a command.
    function automatic result_t step_entry(
        input cmd_t                      cmd,
        input logic [STEP_BITS-1:0]      step,
        input logic [WORD_ADDR_BITS-1:0] addr,
        input logic [DATA_BITS-1:0]      data
    );
        result_t r;
        r.kind = KIND_ERROR;
        r.addr = '0;
        r.data = '0;
        r.last = 1'b1;
        case (cmd)
            CMD_PROGRAM:
            begin
                r.last = 1'b0;
                case (step)
                    3'd0:
                    begin
                        r.kind = KIND_WRITE;
                        r.addr = UNLOCK_A;
                        r.data = DATA_UNLOCK_A;
                    end
                    3'd1:
                    begin
                        r.kind = KIND_WRITE;
                        r.addr = UNLOCK_B;
                        r.data = DATA_UNLOCK_B;
                    end
                    3'd2:
                    begin
                        r.kind = KIND_WRITE;
                        r.addr = UNLOCK_A;
                        r.data = DATA_PROGRAM;
                    end
                    3'd3:
                    begin
                        r.kind = KIND_WRITE;
                        r.addr = addr;
                        r.data = data;
                    end
                    default:
                    begin
                        r.kind = KIND_POLL;
                        r.addr = addr;
                        r.last = 1'b1;
                    end
                endcase
            end
            CMD_ERASE:
            begin
                r.last = 1'b0;
                case (step)
                    3'd0, 3'd3:
                    begin
                        r.kind = KIND_WRITE;
                        r.addr = UNLOCK_A;
                        r.data = DATA_UNLOCK_A;
                    end
                    3'd1, 3'd4:
                    begin
                        r.kind = KIND_WRITE;
                        r.addr = UNLOCK_B;
                        r.data = DATA_UNLOCK_B;
                    end
                    3'd2:
                    begin
                        r.kind = KIND_WRITE;
                        r.addr = UNLOCK_A;
                        r.data = DATA_ERASE;
                    end
                    3'd5:
                    begin
                        r.kind = KIND_WRITE;
                        r.addr = addr;
                        r.data = DATA_SECTOR;
                    end
                    default:
                    begin
                        r.kind = KIND_POLL;
                        r.addr = addr;
                        r.last = 1'b1;
                    end
                endcase
            end
            CMD_RESET:
            begin
                if (step == 3'd0)
                begin
                    r.kind = KIND_WRITE;
                    r.data = DATA_RESET;
                    r.last = 1'b0;
                end
                else
                begin
                    r.kind = KIND_DONE;
                end
            end
            CMD_POLL:
            begin
                r.kind = KIND_POLL;
                r.addr = addr;
            end
            CMD_DONE:
            begin
                r.kind = KIND_DONE;
                r.addr = addr;
            end
            default:
            begin
                r.kind = KIND_ERROR;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/nfcs_front.sv
// Front end: accepts requests, tracks the busy state and classifies each request.
module nfcs_front
    import nfcs_pkg::*;
#(
    parameter int BYTE_ADDR_BITS = 22
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [1:0]                op,
    input  logic [BYTE_ADDR_BITS-1:0] byte_address,
    input  logic [DATA_BITS-1:0]      write_value,
    input  logic [DATA_BITS-1:0]      read_first,
    input  logic [DATA_BITS-1:0]      read_second,
    output desc_t                     desc
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [WORD_ADDR_BITS-1:0] poll_addr_reg;
    logic [WORD_ADDR_BITS-1:0] poll_addr_next;
    logic [31:0]               addr_ext;
    logic [WORD_ADDR_BITS-1:0] word;
    op_t                       op_in;

    assign addr_ext = 32'(byte_address);
    assign word     = addr_ext[WORD_ADDR_BITS:1];
    assign op_in    = op_t'(op);

    always_comb
    begin
        busy_next      = busy_reg;
        poll_addr_next = poll_addr_reg;
        desc.cmd       = CMD_ERROR;
        desc.addr      = '0;
        desc.data      = '0;
        if (op_in == OP_STATUS)
        begin
            if (!busy_reg)
            begin
                desc.cmd = CMD_ERROR;
            end
            else if (read_first[DQ6_BIT] != read_second[DQ6_BIT])
            begin
                // DQ6 still toggling: the operation is in progress.
                desc.cmd  = CMD_POLL;
                desc.addr = poll_addr_reg;
            end
            else
            begin
                desc.cmd  = CMD_DONE;
                desc.addr = poll_addr_reg;
                busy_next = 1'b0;
            end
        end
        else if (busy_reg)
        begin
            desc.cmd = CMD_ERROR;
        end
        else
        begin
            case (op_in)
                OP_PROGRAM:
                begin
                    desc.cmd       = CMD_PROGRAM;
                    desc.addr      = word;
                    desc.data      = write_value;
                    busy_next      = 1'b1;
                    poll_addr_next = word;
                end
                OP_ERASE:
                begin
                    desc.cmd       = CMD_ERASE;
                    desc.addr      = word;
                    busy_next      = 1'b1;
                    poll_addr_next = word;
                end
                default:
                begin
                    desc.cmd = CMD_RESET;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            poll_addr_reg <= '0;
        end
        else if (accept)
        begin
            busy_reg      <= busy_next;
            poll_addr_reg <= poll_addr_next;
        end
    end

endmodule

>>> rtl/nfcs_queue.sv
// Short command queue between the front and back ends.
module nfcs_queue
    import nfcs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  desc_t wr_desc,
    output logic  full,
    input  logic  rd_en,
    output desc_t rd_desc,
    output logic  empty
);

    desc_t                  entry_reg [CQ_DEPTH];
    logic [CQ_IDX_BITS-1:0] wr_ptr_reg;
    logic [CQ_IDX_BITS-1:0] rd_ptr_reg;
    logic [CQ_CNT_BITS-1:0] count_reg;
    logic                   do_wr;
    logic                   do_rd;

    assign full    = (count_reg == CQ_CNT_BITS'(CQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_desc = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/nfcs_back.sv
// Back end: steps through queued commands; one result per cycle unless stalled.
`include "nor_flash_command_sequencer_defines.svh"

module nfcs_back
    import nfcs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  desc_t                     head,
    input  logic                      head_valid,
    output logic                      head_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [1:0]                kind,
    output logic [WORD_ADDR_BITS-1:0] word_address,
    output logic [DATA_BITS-1:0]      bus_data,
    output logic                      last
);

    logic [STEP_BITS-1:0] step_reg;
    logic                 out_valid_reg;
    result_t              out_res_reg;
    result_t              ent;
    logic                 advance;
    logic                 taken;

    assign ent     = step_entry(head.cmd, step_reg, head.addr, head.data);
    assign taken   = pop && out_valid_reg;
    // The output register takes a new result when it is empty or being drained.
    assign advance = head_valid && (!out_valid_reg || taken);
    assign head_pop = advance && ent.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (ent.last)
                begin
                    step_reg <= '0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            else if (taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= ent;
        end
    end

    assign empty        = !out_valid_reg;
    assign kind         = out_res_reg.kind;
    assign word_address = out_res_reg.addr;
    assign bus_data     = out_res_reg.data;
    assign last         = out_res_reg.last;

    `NFCS_ASSERT_NEVER(a_step_range, step_reg > MAX_STEP)
    `NFCS_ASSERT(a_step_has_head, (step_reg != '0) |-> head_valid)
    `NFCS_ASSERT(a_pop_on_last, head_pop |=> (out_valid_reg && out_res_reg.last))
    `NFCS_ASSERT(a_mid_command_not_last, (advance && !ent.last) |=> !out_res_reg.last)

endmodule

>>> rtl/nor_flash_command_sequencer.sv
// Top level of the NOR flash command sequencer: front end, command queue and back end.
//
//   Channel   Signals                                             Handshake
//   request   op, byte_address, write_value, read_first,          push / full
//             read_second
//   result    kind, word_address, bus_data, last                  pop / empty
//
// A request is taken in any cycle in which the four-entry command queue has room.
// The back end emits one result per cycle into an output register while a command
// is queued and the consumer is not stalling: a program request gives three command
// writes, the data write and a poll, a sector erase six writes and a poll, a reset
// its write and a done, a status or refused request one result. Reset clears the busy
// flag, poll address, queue and the output valid bit; no clearing pass is needed.
module nor_flash_command_sequencer
    import nfcs_pkg::*;
#(
    parameter int BYTE_ADDR_BITS = 22
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                op,
    input  logic [BYTE_ADDR_BITS-1:0] byte_address,
    input  logic [15:0]               write_value,
    input  logic [15:0]               read_first,
    input  logic [15:0]               read_second,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                kind,
    output logic [20:0]               word_address,
    output logic [15:0]               bus_data,
    output logic                      last
);

    desc_t front_desc;
    desc_t head_desc;
    logic  accept;
    logic  q_empty;
    logic  head_pop;

    assign accept = push && !full;

    nfcs_front #(
        .BYTE_ADDR_BITS (BYTE_ADDR_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (op),
        .byte_address (byte_address),
        .write_value  (write_value),
        .read_first   (read_first),
        .read_second  (read_second),
        .desc         (front_desc)
    );

    nfcs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_desc (front_desc),
        .full    (full),
        .rd_en   (head_pop),
        .rd_desc (head_desc),
        .empty   (q_empty)
    );

    nfcs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_desc),
        .head_valid   (!q_empty),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .kind         (kind),
        .word_address (word_address),
        .bus_data     (bus_data),
        .last         (last)
    );

endmodule

>>> dv/nfcs_checker.sv
// Checker for the NOR flash command sequencer: predicts and compares each request's bus accesses.
`timescale 1ns / 1ps

module nfcs_checker
    import nfcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  op,
    input  logic [21:0] byte_address,
    input  logic [15:0] write_value,
    input  logic [15:0] read_first,
    input  logic [15:0] read_second,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  kind,
    input  logic [20:0] word_address,
    input  logic [15:0] bus_data,
    input  logic        last,
    output int          mismatches,
    output int          outstanding
);

    result_t                   expected_bus_ops[$];
    logic                      flash_busy;
    logic [WORD_ADDR_BITS-1:0] polled_word;
    int                        bad_count = 0;

    task automatic queue_access(
        input kind_t                     k,
        input logic [WORD_ADDR_BITS-1:0] addr,
        input logic [DATA_BITS-1:0]      data,
        input logic                      fin
    );
        result_t r;
        r.kind = k;
        r.addr = addr;
        r.data = data;
        r.last = fin;
        expected_bus_ops.push_back(r);
    endtask

    // Works out every bus access that one accepted request must produce.
    task automatic sequence_request(
        input logic [1:0]  code,
        input logic [21:0] baddr,
        input logic [15:0] wv,
        input logic [15:0] read_a,
        input logic [15:0] read_b
    );
        logic [WORD_ADDR_BITS-1:0] word;
        word = baddr[21:1];
        if (code == OP_STATUS)
        begin
            if (!flash_busy)
                queue_access(KIND_ERROR, '0, '0, 1'b1);
            else if (read_a[DQ6_BIT] != read_b[DQ6_BIT])
                queue_access(KIND_POLL, polled_word, '0, 1'b1);
            else
            begin
                queue_access(KIND_DONE, polled_word, '0, 1'b1);
                flash_busy = 1'b0;
            end
        end
        else if (flash_busy)
        begin
            queue_access(KIND_ERROR, '0, '0, 1'b1);
        end
        else if (code == OP_RESET)
        begin
            queue_access(KIND_WRITE, '0, DATA_RESET, 1'b0);
            queue_access(KIND_DONE, '0, '0, 1'b1);
        end
        else
        begin
            queue_access(KIND_WRITE, UNLOCK_A, DATA_UNLOCK_A, 1'b0);
            queue_access(KIND_WRITE, UNLOCK_B, DATA_UNLOCK_B, 1'b0);
            if (code == OP_PROGRAM)
            begin
                queue_access(KIND_WRITE, UNLOCK_A, DATA_PROGRAM, 1'b0);
                queue_access(KIND_WRITE, word, wv, 1'b0);
            end
            else
            begin
                queue_access(KIND_WRITE, UNLOCK_A, DATA_ERASE, 1'b0);
                queue_access(KIND_WRITE, UNLOCK_A, DATA_UNLOCK_A, 1'b0);
                queue_access(KIND_WRITE, UNLOCK_B, DATA_UNLOCK_B, 1'b0);
                queue_access(KIND_WRITE, word, DATA_SECTOR, 1'b0);
            end
            queue_access(KIND_POLL, word, '0, 1'b1);
            flash_busy  = 1'b1;
            polled_word = word;
        end
    endtask

    task automatic check_bus_op();
        result_t want;
        if (expected_bus_ops.size() == 0)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("%0t: unexpected result kind=%0d addr=%h data=%h last=%b",
                         $realtime, kind, word_address, bus_data, last);
        end
        else
        begin
            want = expected_bus_ops.pop_front();
            if (kind !== want.kind || word_address !== want.addr ||
                bus_data !== want.data || last !== want.last)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display({"%0t: expected kind=%0d addr=%h data=%h last=%b, ",
                              "got kind=%0d addr=%h data=%h last=%b"},
                             $realtime, want.kind, want.addr, want.data, want.last,
                             kind, word_address, bus_data, last);
            end
        end
    endtask

    // A result never leaves in the cycle its request is taken, so results are checked first.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_busy  = 1'b0;
            polled_word = '0;
            expected_bus_ops.delete();
        end
        else
        begin
            if (pop && !empty)
                check_bus_op();
            if (push && !full)
                sequence_request(op, byte_address, write_value, read_first, read_second);
        end
        mismatches  = bad_count;
        outstanding = expected_bus_ops.size();
    end

endmodule

>>> dv/tb_top.sv
// Top of the NOR flash command sequencer testbench: clock, reset, request and result traffic.
`timescale 1ns / 1ps

module tb_top
    import nfcs_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  op;
    logic [21:0] byte_address;
    logic [15:0] write_value;
    logic [15:0] read_first;
    logic [15:0] read_second;
    logic        empty;
    logic        pop;
    logic [1:0]  kind;
    logic [20:0] word_address;
    logic [15:0] bus_data;
    logic        last;

    int mismatches;
    int outstanding;
    int sent = 0;
    bit no_gaps = 1'b0;
    bit squeeze = 1'b0;

    nor_flash_command_sequencer #(
        .BYTE_ADDR_BITS(22)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .byte_address (byte_address),
        .write_value  (write_value),
        .read_first   (read_first),
        .read_second  (read_second),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .word_address (word_address),
        .bus_data     (bus_data),
        .last         (last)
    );

    nfcs_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .byte_address (byte_address),
        .write_value  (write_value),
        .read_first   (read_first),
        .read_second  (read_second),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .word_address (word_address),
        .bus_data     (bus_data),
        .last         (last),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [21:0] pick_byte_address();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return 22'h3FFFFF;
        return 22'($urandom);
    endfunction

    task automatic issue_request(
        input op_t         code,
        input logic [21:0] addr,
        input logic [15:0] wv,
        input logic [15:0] read_a,
        input logic [15:0] read_b
    );
        int gap;
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        op           <= code;
        byte_address <= addr;
        write_value  <= wv;
        read_first   <= read_a;
        read_second  <= read_b;
        do
            @(posedge clk);
        while (full);
        sent++;
    endtask

    // A status request whose two reads toggle DQ6 or not; all other bits are random.
    task automatic status_reads(input bit toggling);
        logic [15:0] read_a;
        logic [15:0] flip;
        read_a = 16'($urandom);
        flip   = 16'($urandom);
        flip[DQ6_BIT] = toggling;
        issue_request(OP_STATUS, pick_byte_address(), 16'($urandom), read_a, read_a ^ flip);
    endtask

    // Result side: random stalls, and one long hold-off while the request side keeps pushing.
    initial
    begin
        int hold;
        bit squeezed;
        pop = 1'b0;
        squeezed = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (squeeze && !squeezed)
            begin
                squeezed = 1'b1;
                hold = 150;
            end
            else
            begin
                hold = no_gaps ? 0 : gap_len();
            end
            if (hold > 0)
            begin
                pop <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        int pick;
        int polls;
        int burst_end;
        rst_n        = 1'b0;
        push         = 1'b0;
        op           = OP_PROGRAM;
        byte_address = '0;
        write_value  = '0;
        read_first   = '0;
        read_second  = '0;
        burst_end    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: every operation, refused requests and address extremes.
        issue_request(OP_RESET, 22'h3FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        issue_request(OP_STATUS, '0, '0, 16'h0040, 16'h0000);
        issue_request(OP_PROGRAM, '0, '0, '0, '0);
        issue_request(OP_PROGRAM, 22'h155555, 16'h1234, '0, '0);
        issue_request(OP_ERASE, 22'h3FFFFF, 16'hFFFF, '0, '0);
        issue_request(OP_RESET, '0, '0, '0, '0);
        issue_request(OP_STATUS, '0, '0, 16'h0040, 16'h0000);
        issue_request(OP_STATUS, 22'h3FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFBF);
        issue_request(OP_STATUS, '0, '0, 16'hFFFF, 16'h0040);
        issue_request(OP_PROGRAM, 22'h3FFFFF, 16'hFFFF, '0, '0);
        issue_request(OP_STATUS, '0, '0, 16'h0000, 16'h0000);
        issue_request(OP_ERASE, 22'h3FFFFE, 16'h0000, 16'hFFFF, 16'hFFFF);
        issue_request(OP_STATUS, '0, '0, 16'hFFFF, 16'hFFFF);
        issue_request(OP_ERASE, 22'h000001, 16'hA5A5, '0, '0);
        issue_request(OP_STATUS, 22'h2AAAAA, '0, 16'h0000, 16'hFFBF);
        issue_request(OP_STATUS, 22'h3FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        issue_request(OP_PROGRAM, 22'h2AAAAB, 16'h5555, '0, '0);
        issue_request(OP_STATUS, '0, '0, 16'h00BF, 16'h00FF);
        issue_request(OP_STATUS, '0, '0, 16'h8001, 16'h7FFE);
        issue_request(OP_RESET, 22'h1FFFFF, 16'h8000, 16'h8000, 16'h0001);

        // Random part: mostly complete program or erase sequences, some resets and noise.
        while (sent < 430)
        begin
            if (!squeeze && sent >= 180)
            begin
                squeeze   = 1'b1;
                no_gaps   = 1'b1;
                burst_end = sent + 40;
            end
            if (no_gaps && sent >= burst_end)
                no_gaps = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                issue_request(pick < 45 ? OP_PROGRAM : OP_ERASE, pick_byte_address(),
                              16'($urandom), 16'($urandom), 16'($urandom));
                polls = $urandom_range(0, 4);
                repeat (polls)
                begin
                    if ($urandom_range(0, 9) == 0)
                        issue_request(op_t'($urandom_range(0, 2)), pick_byte_address(),
                                      16'($urandom), 16'($urandom), 16'($urandom));
                    status_reads(1'b1);
                end
                status_reads(1'b0);
            end
            else if (pick < 82)
            begin
                issue_request(OP_RESET, pick_byte_address(),
                              16'($urandom), 16'($urandom), 16'($urandom));
            end
            else
            begin
                issue_request(op_t'($urandom_range(0, 3)), pick_byte_address(),
                              16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
        push <= 1'b0;

        // Let the checker see the last accepted request before waiting for the drain.
        @(posedge clk);
        wait (outstanding == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
